@@ rtl/dlpe_pkg.sv @@
// ----------------------------------------------------------------------------
// dlpe_pkg: shared definitions of the line program encoder
// Opcodes, register indexes, channel payloads and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dlpe_pkg;

  // Parameter defaults.
  localparam int unsigned ADDR_BITS_DEF     = 32;
  localparam int unsigned FIRST_SPECIAL_DEF = 5;

  // Standard opcodes.
  localparam logic [7:0] OP_COPY     = 8'h01;
  localparam logic [7:0] OP_ADV_PC   = 8'h02;
  localparam logic [7:0] OP_ADV_LINE = 8'h03;

  // Reset values of the configuration registers.
  localparam logic signed [7:0] WIN_BASE_RST  = -8'sd1;
  localparam logic [7:0]        WIN_RANGE_RST = 8'd5;

  // The reference line after reset or a start request.
  localparam logic [30:0] REF_LINE_INIT = 31'd1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIN_BASE  = 1'b0,
    REG_WIN_RANGE = 1'b1
  } cfg_reg_e;

  // Input row payload.
  typedef struct packed {
    logic        start_req;
    logic [31:0] address;
    logic [30:0] line;
  } row_t;

  // Output byte payload.
  typedef struct packed {
    logic [7:0] byte_res;
    logic       last;
    logic       order_error;
  } prog_byte_t;

  // Source of the byte loaded into the output register.
  typedef enum logic [2:0] {
    SEL_COPY,
    SEL_SPECIAL,
    SEL_ADV_LINE,
    SEL_ADV_PC,
    SEL_LEB,
    SEL_ERR
  } byte_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic      load;     // Capture an accepted row.
    logic      calc;     // Form the deltas and the order check.
    logic      mult;     // Form the special opcode terms and the branch flags.
    logic      emit;     // Load one byte into the output register.
    byte_sel_e sel;
    logic      last;
    logic      upd_ref;  // The row becomes the new reference.
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic can_emit;
    logic order_err;
    logic both_zero;
    logic special_ok;
    logic mag_gt;
    logic leb_done;
  } status_t;

endpackage

@@ rtl/dlpe_stream_if.sv @@
// ----------------------------------------------------------------------------
// dlpe_stream_if: valid/ready channel
// Carries one payload of type T per beat from a source to a sink.
// ----------------------------------------------------------------------------
interface dlpe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dlpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlpe_ctrl: encoder sequencer
// Walks each row through delta calculation, opcode choice and LEB128 output.
// ----------------------------------------------------------------------------
module dlpe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dlpe_pkg::status_t sts_i,
  output dlpe_pkg::cmd_t    cmd_o
);
  import dlpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MULT,
    S_DECIDE,
    S_LEB,
    S_ERR
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, calc: 1'b0, mult: 1'b0, emit: 1'b0,
                sel: SEL_COPY, last: 1'b0, upd_ref: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = sts_i.order_err ? S_ERR : S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          if (sts_i.both_zero || sts_i.special_ok) begin
            cmd_o.sel     = sts_i.both_zero ? SEL_COPY : SEL_SPECIAL;
            cmd_o.last    = 1'b1;
            cmd_o.upd_ref = 1'b1;
            state_d       = S_IDLE;
          end else begin
            cmd_o.sel = sts_i.mag_gt ? SEL_ADV_LINE : SEL_ADV_PC;
            state_d   = S_LEB;
          end
        end
      end
      S_LEB: begin
        if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_LEB;
          if (sts_i.leb_done) begin
            state_d = S_MULT;
          end
        end
      end
      S_ERR: begin
        if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_ERR;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/dlpe_datapath.sv @@
// ----------------------------------------------------------------------------
// dlpe_datapath: encoder datapath
// Holds the reference row, the deltas, the LEB128 shifter, the configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module dlpe_datapath #(
  parameter int unsigned ADDR_BITS     = dlpe_pkg::ADDR_BITS_DEF,
  parameter int unsigned FIRST_SPECIAL = dlpe_pkg::FIRST_SPECIAL_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  dlpe_pkg::row_t       row_i,
  input  dlpe_pkg::cmd_t       cmd_i,
  output dlpe_pkg::status_t    sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dlpe_pkg::prog_byte_t out_o
);
  import dlpe_pkg::*;

  // Common width of the two deltas, and the LEB128 shifter with a sign bit on top.
  localparam int unsigned MW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int unsigned LW = MW + 1;

  logic signed [7:0]     lb_q;
  logic [7:0]            lr_q;
  logic [ADDR_BITS-1:0]  ref_addr_q;
  logic [30:0]           ref_line_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [30:0]           line_q;
  logic signed [31:0]    dline_q;
  logic [ADDR_BITS-1:0]  daddr_q;
  logic                  err_q;
  logic                  win_q;
  logic [7:0]            diff_q;
  logic [15:0]           prod_q;
  logic                  mag_gt_q;
  logic signed [LW-1:0]  leb_q;
  logic                  leb_sgn_q;
  logic                  out_valid_q;
  prog_byte_t            out_q;

  logic signed [31:0]    lb_ext;
  logic signed [31:0]    win_hi;
  logic signed [31:0]    diff;
  logic [31:0]           mag;
  logic [16:0]           op_full;
  logic signed [LW-1:0]  leb_next;
  logic                  leb_done;
  logic                  can_emit;
  logic [7:0]            byte_d;

  // Special opcode window terms.
  assign lb_ext = {{24{lb_q[7]}}, lb_q};
  assign win_hi = lb_ext + $signed({24'd0, lr_q});
  assign diff   = dline_q - lb_ext;
  assign mag    = dline_q[31] ? 32'(-dline_q) : 32'(dline_q);

  assign op_full = {9'd0, diff_q} + {1'b0, prod_q} + 17'(FIRST_SPECIAL);

  // LEB128 step: seven bits out, arithmetic shift keeps the sign for the signed form.
  assign leb_next = leb_q >>> 7;
  assign leb_done = leb_sgn_q ? (leb_next == {LW{leb_q[6]}}) : (leb_next == '0);

  assign can_emit = !out_valid_q || out_ready_i;

  assign sts_o = '{can_emit:   can_emit,
                   order_err:  err_q,
                   both_zero:  (dline_q == '0) && (daddr_q == '0),
                   special_ok: win_q && (op_full <= 17'd255),
                   mag_gt:     mag_gt_q,
                   leb_done:   leb_done};

  always_comb begin
    case (cmd_i.sel)
      SEL_COPY:     byte_d = OP_COPY;
      SEL_SPECIAL:  byte_d = op_full[7:0];
      SEL_ADV_LINE: byte_d = OP_ADV_LINE;
      SEL_ADV_PC:   byte_d = OP_ADV_PC;
      SEL_LEB:      byte_d = {!leb_done, leb_q[6:0]};
      SEL_ERR:      byte_d = 8'h00;
      default:      byte_d = 8'h00;
    endcase
  end

  // Configuration, reference row and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q        <= WIN_BASE_RST;
      lr_q        <= WIN_RANGE_RST;
      ref_addr_q  <= '0;
      ref_line_q  <= REF_LINE_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WIN_BASE:  lb_q <= cfg_data_i;
          REG_WIN_RANGE: lr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && row_i.start_req) begin
        ref_addr_q <= '0;
        ref_line_q <= REF_LINE_INIT;
      end else if (cmd_i.upd_ref) begin
        ref_addr_q <= addr_q;
        ref_line_q <= line_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= ADDR_BITS'(row_i.address);
      line_q <= row_i.line;
    end
    if (cmd_i.calc) begin
      err_q   <= addr_q < ref_addr_q;
      dline_q <= $signed({1'b0, line_q}) - $signed({1'b0, ref_line_q});
      daddr_q <= addr_q - ref_addr_q;
    end
    if (cmd_i.mult) begin
      win_q    <= (dline_q >= lb_ext) && (dline_q < win_hi) && (daddr_q <= ADDR_BITS'(255));
      diff_q   <= diff[7:0];
      prod_q   <= 16'(lr_q) * 16'(daddr_q[7:0]);
      mag_gt_q <= MW'(mag) > MW'(daddr_q);
    end
    if (cmd_i.emit) begin
      out_q <= '{byte_res: byte_d, last: cmd_i.last, order_error: cmd_i.sel == SEL_ERR};
      case (cmd_i.sel)
        SEL_ADV_LINE: begin
          leb_q     <= LW'(dline_q);
          leb_sgn_q <= 1'b1;
          dline_q   <= '0;
        end
        SEL_ADV_PC: begin
          leb_q     <= $signed(LW'(daddr_q));
          leb_sgn_q <= 1'b0;
          daddr_q   <= '0;
        end
        SEL_LEB: begin
          leb_q <= leb_next;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ rtl/dwarf_line_program_encoder.sv @@
// ----------------------------------------------------------------------------
// dwarf_line_program_encoder: line-number program byte encoder
// Turns (address, line) rows into line-number program bytes.
// ----------------------------------------------------------------------------
// Usage. Rows arrive on row_if, one per beat; each row yields one to thirteen
// beats on byte_if, the final one marked by last. A row equal to the
// reference row gives a copy opcode; a small change gives one special opcode;
// larger changes give advance_line and/or advance_pc with a LEB128 operand,
// followed by a copy or special opcode. A start_req row first resets the
// reference to address 0, line 1. A row whose address lies below the
// reference gives a single beat with byte 0, last and order_error set, and
// leaves the reference unchanged.
// Flow. One row is handled at a time. The sequencer accepts the row, forms the
// deltas and the multiply terms for the special opcode, then loads the bytes
// one by one, with another multiply step after each advance group. The output
// register sends at most one beat per cycle; when the receiver stalls the
// register holds its beat and the sequencer waits.
// Reset sets the reference row to address 0, line 1, the window base to -1
// and the window range to 5. Configuration writes via cfg_we_i must be made
// between rows; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dwarf_line_program_encoder #(
  parameter int unsigned ADDR_BITS     = dlpe_pkg::ADDR_BITS_DEF,
  parameter int unsigned FIRST_SPECIAL = dlpe_pkg::FIRST_SPECIAL_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  dlpe_stream_if.sink   row_if,
  dlpe_stream_if.source byte_if
);
  import dlpe_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The sequencer only handshakes the row channel; the payload goes to the datapath.
  dlpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (row_if.valid),
    .in_ready_o (row_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlpe_datapath #(
    .ADDR_BITS     (ADDR_BITS),
    .FIRST_SPECIAL (FIRST_SPECIAL)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (row_if.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (byte_if.ready),
    .out_valid_o (byte_if.valid),
    .out_o       (byte_if.data)
  );

endmodule
